@@ hdl/crc_checked_frame_parser_unit_macros.svh @@
// Assertion helpers for the frame parser checker.
`ifndef CRC_CHECKED_FRAME_PARSER_UNIT_MACROS_SVH
`define CRC_CHECKED_FRAME_PARSER_UNIT_MACROS_SVH

// Concurrent check on the rising clock edge, held off while in reset.
`define CFPU_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("frame parser check failed");

// Same-cycle implication.
`define CFPU_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
  `CFPU_ASSERT(lbl, clk, rstn, (ante) |-> (cons))

`endif

@@ hdl/cfpu_pkg.sv @@
`default_nettype none
package cfpu_pkg;

  localparam int MaxPayload = 32;
  localparam int IdxW       = $clog2(MaxPayload);
  localparam int LenW       = 6;
  localparam int AddrW      = IdxW + 1;  // two payload banks
  localparam int FifoDepth  = 2;
  localparam int FifoPtrW   = $clog2(FifoDepth);
  localparam int FifoCntW   = $clog2(FifoDepth + 1);

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'h1021;
  localparam logic [15:0] CntMax  = 16'hFFFF;
  localparam logic [7:0]  MarkerReset = 8'hAA;

  typedef enum logic [1:0] {
    KIND_GOOD    = 2'd0,
    KIND_CRC_ERR = 2'd1,
    KIND_LEN_ERR = 2'd2
  } kind_e;

  // frame outcome handed from front to back
  typedef struct packed {
    kind_e             kind;
    logic [7:0]        cmd;
    logic [LenW-1:0]   len;
    logic [15:0]       errcnt;
    logic              bank;
  } desc_t;

  typedef struct packed {
    logic              en;
    logic [AddrW-1:0]  addr;
    logic [7:0]        data;
  } wr_t;

  // back is done reading a bank
  typedef struct packed {
    logic              en;
    logic              bank;
  } rel_t;

  function automatic logic [15:0] crc_upd(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ((c << 1) ^ CrcPoly) : (c << 1);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

@@ hdl/cfpu_if.sv @@
`default_nettype none
interface cfpu_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source(output valid, output rx_byte, input ready);
  modport sink(input valid, input rx_byte, output ready);
endinterface

interface cfpu_res_if import cfpu_pkg::*; ();
  logic            valid;
  logic            ready;
  kind_e           kind;
  logic [7:0]      command;
  logic [LenW-1:0] length;
  logic [IdxW-1:0] index;
  logic [7:0]      data;
  logic            last;
  logic [15:0]     crc_error_count;

  modport source(output valid, output kind, output command, output length, output index,
                 output data, output last, output crc_error_count, input ready);
  modport sink(input valid, input kind, input command, input length, input index,
               input data, input last, input crc_error_count, output ready);
endinterface
`default_nettype wire

@@ hdl/crc_checked_frame_parser_unit.sv @@
// Outcomes pushed at the CRC low byte (or bad length byte) pass the outcome queue,
// current-frame register, read stage and output register. Throughput: one received byte per
// cycle in; one result word per cycle out within a run while the receiver is ready; runs do
// not overlap. Payload bytes wait while both payload banks still hold frames the back end has
// not read. Outcome queue holds 2 frames; length byte and CRC low byte wait while it is full.
// Reset: parser hunts, start marker 0xAA, CRC error count 0; no payload clearing pass.
`default_nettype none
module crc_checked_frame_parser_unit import cfpu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  cfpu_rx_if.sink    rx_i,
  cfpu_res_if.source res_o
);

  logic  push, full, pop, nonempty;
  desc_t push_desc, pop_desc;
  wr_t   wr;
  rel_t  rel;

  cfpu_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .rx_i        (rx_i),
    .push_o      (push),
    .push_desc_o (push_desc),
    .full_i      (full),
    .wr_o        (wr),
    .rel_i       (rel)
  );

  cfpu_desc_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_desc_i (push_desc),
    .full_o      (full),
    .pop_i       (pop),
    .nonempty_o  (nonempty),
    .pop_desc_o  (pop_desc)
  );

  cfpu_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (wr),
    .nonempty_i (nonempty),
    .desc_i     (pop_desc),
    .pop_o      (pop),
    .rel_o      (rel),
    .res_o      (res_o)
  );

endmodule
`default_nettype wire

@@ hdl/cfpu_front.sv @@
`default_nettype none
module cfpu_front import cfpu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  cfpu_rx_if.sink    rx_i,
  output logic       push_o,
  output desc_t      push_desc_o,
  input  logic       full_i,
  output wr_t        wr_o,
  input  rel_t       rel_i
);

  localparam logic [2:0] PhHunt = 3'd0;
  localparam logic [2:0] PhLen  = 3'd1;
  localparam logic [2:0] PhCmd  = 3'd2;
  localparam logic [2:0] PhPay  = 3'd3;
  localparam logic [2:0] PhChi  = 3'd4;
  localparam logic [2:0] PhClo  = 3'd5;

  logic [2:0]      phase_q, phase_d;
  logic [LenW-1:0] len_q, len_d;
  logic [LenW-1:0] cnt_q, cnt_d;
  logic [7:0]      cmd_q, cmd_d;
  logic [15:0]     crc_q, crc_d;
  logic [7:0]      chi_q, chi_d;
  logic [15:0]     errcnt_q, errcnt_d;
  logic            bank_q, bank_d;
  logic [1:0]      pend_q, pend_d;
  logic [7:0]      marker_q;

  logic        acc;
  logic [7:0]  b;
  logic [15:0] crc_new;

  // outcome pushes happen in the length and CRC-low phases; payload waits for a free bank
  assign rx_i.ready = !(((phase_q == PhLen) || (phase_q == PhClo)) && full_i) &&
                      !((phase_q == PhPay) && pend_q[bank_q]);
  assign acc = rx_i.valid && rx_i.ready;
  assign b   = rx_i.rx_byte;
  assign crc_new = crc_upd((phase_q == PhLen) ? CrcInit : crc_q, b);

  always_comb begin
    phase_d  = phase_q;
    len_d    = len_q;
    cnt_d    = cnt_q;
    cmd_d    = cmd_q;
    crc_d    = crc_q;
    chi_d    = chi_q;
    errcnt_d = errcnt_q;
    bank_d   = bank_q;
    pend_d   = pend_q;
    push_o   = 1'b0;
    push_desc_o = '{kind: KIND_GOOD, cmd: cmd_q, len: len_q, errcnt: errcnt_q, bank: bank_q};
    wr_o     = '{en: 1'b0, addr: {bank_q, cnt_q[IdxW-1:0]}, data: b};

    if (rel_i.en) begin
      pend_d[rel_i.bank] = 1'b0;
    end

    if (acc) begin
      case (phase_q)
        PhLen: begin
          if (b > 8'(MaxPayload)) begin
            push_o           = 1'b1;
            push_desc_o.kind = KIND_LEN_ERR;
            push_desc_o.cmd  = 8'h00;
            push_desc_o.len  = (b > 8'({LenW{1'b1}})) ? {LenW{1'b1}} : b[LenW-1:0];
            phase_d          = PhHunt;
          end else begin
            len_d   = b[LenW-1:0];
            cnt_d   = '0;
            crc_d   = crc_new;
            phase_d = PhCmd;
          end
        end
        PhCmd: begin
          cmd_d   = b;
          crc_d   = crc_new;
          phase_d = (len_q != '0) ? PhPay : PhChi;
        end
        PhPay: begin
          wr_o.en = 1'b1;
          cnt_d   = cnt_q + LenW'(1);
          crc_d   = crc_new;
          if (cnt_q + LenW'(1) >= len_q) begin
            phase_d = PhChi;
          end
        end
        PhChi: begin
          chi_d   = b;
          phase_d = PhClo;
        end
        PhClo: begin
          phase_d = PhHunt;
          push_o  = 1'b1;
          if ({chi_q, b} != crc_q) begin
            if (errcnt_q != CntMax) begin
              errcnt_d = errcnt_q + 16'd1;
            end
            push_desc_o.kind   = KIND_CRC_ERR;
            push_desc_o.errcnt = errcnt_d;
          end else if (len_q != '0) begin
            pend_d[bank_q] = 1'b1;
            bank_d         = !bank_q;
          end
        end
        default: begin
          phase_d = (b == marker_q) ? PhLen : PhHunt;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhHunt;
      len_q    <= '0;
      cnt_q    <= '0;
      cmd_q    <= '0;
      crc_q    <= CrcInit;
      chi_q    <= '0;
      errcnt_q <= '0;
      bank_q   <= 1'b0;
      pend_q   <= '0;
      marker_q <= MarkerReset;
    end else begin
      phase_q  <= phase_d;
      len_q    <= len_d;
      cnt_q    <= cnt_d;
      cmd_q    <= cmd_d;
      crc_q    <= crc_d;
      chi_q    <= chi_d;
      errcnt_q <= errcnt_d;
      bank_q   <= bank_d;
      pend_q   <= pend_d;
      if (cfg_we_i) begin
        marker_q <= cfg_wdata_i;
      end
    end
  end

endmodule
`default_nettype wire

@@ hdl/cfpu_desc_fifo.sv @@
`default_nettype none
module cfpu_desc_fifo import cfpu_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  desc_t push_desc_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  nonempty_o,
  output desc_t pop_desc_o
);

  desc_t               slot_q [FifoDepth];
  logic [FifoPtrW-1:0] wp_q, rp_q;
  logic [FifoCntW-1:0] cnt_q;
  logic                do_push, do_pop;

  assign full_o     = (cnt_q == FifoCntW'(FifoDepth));
  assign nonempty_o = (cnt_q != '0);
  assign pop_desc_o = slot_q[rp_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && nonempty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wp_q] <= push_desc_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wp_q <= (wp_q == FifoPtrW'(FifoDepth - 1)) ? '0 : wp_q + FifoPtrW'(1);
      end
      if (do_pop) begin
        rp_q <= (rp_q == FifoPtrW'(FifoDepth - 1)) ? '0 : rp_q + FifoPtrW'(1);
      end
      cnt_q <= cnt_q + FifoCntW'(do_push) - FifoCntW'(do_pop);
    end
  end

endmodule
`default_nettype wire

@@ hdl/cfpu_back.sv @@
`default_nettype none
module cfpu_back import cfpu_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  wr_t   wr_i,
  input  logic  nonempty_i,
  input  desc_t desc_i,
  output logic  pop_o,
  output rel_t  rel_o,
  cfpu_res_if.source res_o
);

  typedef struct packed {
    kind_e           kind;
    logic [7:0]      cmd;
    logic [LenW-1:0] len;
    logic [IdxW-1:0] idx;
    logic            last;
    logic [15:0]     errcnt;
    logic            use_mem;
  } meta_t;

  logic [7:0]      mem_q [2 * MaxPayload];
  logic [7:0]      rd_data_q;

  logic            act_q;
  desc_t           cur_q;
  logic [IdxW-1:0] idx_q;
  logic            rd_pend_q;
  meta_t           rd_meta_q;
  logic            out_valid_q;
  meta_t           out_meta_q;
  logic [7:0]      out_data_q;

  logic move, issue, use_mem, last_cur;

  assign use_mem  = (cur_q.kind == KIND_GOOD) && (cur_q.len != '0);
  assign last_cur = !use_mem || ((LenW'(idx_q) + LenW'(1)) == cur_q.len);
  assign move     = rd_pend_q && (!out_valid_q || res_o.ready);
  assign issue    = act_q && (!rd_pend_q || move);
  assign pop_o    = !act_q && nonempty_i;
  assign rel_o    = '{en: issue && use_mem && last_cur, bank: cur_q.bank};

  // payload store, two banks
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    if (issue && use_mem) begin
      rd_data_q <= mem_q[{cur_q.bank, idx_q}];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= desc_i;
    end
    if (issue) begin
      rd_meta_q <= '{kind: cur_q.kind, cmd: cur_q.cmd, len: cur_q.len, idx: idx_q,
                     last: last_cur, errcnt: cur_q.errcnt, use_mem: use_mem};
    end
    if (move) begin
      out_meta_q <= rd_meta_q;
      out_data_q <= rd_meta_q.use_mem ? rd_data_q : 8'h00;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q       <= 1'b0;
      idx_q       <= '0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        act_q <= 1'b1;
        idx_q <= '0;
      end else if (issue) begin
        act_q <= !last_cur;
        idx_q <= last_cur ? '0 : idx_q + IdxW'(1);
      end
      if (issue) begin
        rd_pend_q <= 1'b1;
      end else if (move) begin
        rd_pend_q <= 1'b0;
      end
      if (move) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign res_o.valid           = out_valid_q;
  assign res_o.kind            = out_meta_q.kind;
  assign res_o.command         = out_meta_q.cmd;
  assign res_o.length          = out_meta_q.len;
  assign res_o.index           = out_meta_q.idx;
  assign res_o.data            = out_data_q;
  assign res_o.last            = out_meta_q.last;
  assign res_o.crc_error_count = out_meta_q.errcnt;

endmodule
`default_nettype wire

@@ hdl/cfpu_checker.sv @@
`default_nettype none
`include "crc_checked_frame_parser_unit_macros.svh"
module cfpu_checker import cfpu_pkg::*; (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            res_valid_i,
  input logic            res_ready_i,
  input kind_e           res_kind_i,
  input logic [7:0]      res_command_i,
  input logic [LenW-1:0] res_length_i,
  input logic [IdxW-1:0] res_index_i,
  input logic [7:0]      res_data_i,
  input logic            res_last_i
);

  // error words are single, zero-data runs
  `CFPU_ASSERT_IMPLY(a_err_shape, clk_i, rst_ni, (res_valid_i && (res_kind_i != KIND_GOOD)), (res_last_i && (res_index_i == '0) && (res_data_i == 8'h00)))

  `CFPU_ASSERT_IMPLY(a_len_err, clk_i, rst_ni, (res_valid_i && (res_kind_i == KIND_LEN_ERR)), ((res_command_i == 8'h00) && (res_length_i > LenW'(MaxPayload))))

  // payload runs: index inside frame, last only on the final byte
  `CFPU_ASSERT_IMPLY(a_run_last, clk_i, rst_ni, (res_valid_i && (res_kind_i == KIND_GOOD) && (res_length_i != '0)), ((LenW'(res_index_i) < res_length_i) && (res_last_i == ((LenW'(res_index_i) + LenW'(1)) == res_length_i))))

  `CFPU_ASSERT(a_out_hold, clk_i, rst_ni, (res_valid_i && !res_ready_i) |=> (res_valid_i && $stable(res_data_i) && $stable(res_index_i)))

endmodule

bind crc_checked_frame_parser_unit cfpu_checker u_cfpu_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .res_valid_i   (res_o.valid),
  .res_ready_i   (res_o.ready),
  .res_kind_i    (res_o.kind),
  .res_command_i (res_o.command),
  .res_length_i  (res_o.length),
  .res_index_i   (res_o.index),
  .res_data_i    (res_o.data),
  .res_last_i    (res_o.last)
);
`default_nettype wire

@@ tb/tb_crc_checked_frame_parser_unit.sv @@
`timescale 1ns / 1ps
module tb_crc_checked_frame_parser_unit;
  import cfpu_pkg::*;

  typedef enum logic [2:0] {
    SCAN_HUNT,
    SCAN_LEN,
    SCAN_CMD,
    SCAN_PAYLOAD,
    SCAN_CRC_HI,
    SCAN_CRC_LO
  } scan_e;

  typedef struct packed {
    kind_e           kind;
    logic [7:0]      command;
    logic [LenW-1:0] length;
    logic [IdxW-1:0] index;
    logic [7:0]      data;
    logic            last;
    logic [15:0]     crc_errs;
  } frame_word_t;

  localparam int WatchdogLimit = 3000;
  localparam int HoldoffCycles = 300;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we;
  logic [7:0] cfg_wdata;

  cfpu_rx_if  rx_if();
  cfpu_res_if res_if();

  crc_checked_frame_parser_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .rx_i        (rx_if),
    .res_o       (res_if)
  );

  // line bytes waiting to be sent, expected result words
  logic [7:0]  line_bytes_q[$];
  frame_word_t exp_words_q[$];

  // parser shadow state
  scan_e       scan;
  logic [7:0]  marker;
  logic [5:0]  frame_len;
  logic [7:0]  frame_cmd;
  int          rx_count;
  logic [15:0] crc_acc;
  logic [7:0]  crc_hi;
  logic [7:0]  payload_mem [MaxPayload];
  logic [15:0] crc_errs;

  bit gaps_off;
  int fail_count;
  int words_seen;
  int holdoff_left;
  bit holdoff_done;
  int idle_cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [15:0] crc_ccitt_next(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] r;
    logic        fb;
    r = acc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[15] ^ b[i];
      r  = {r[14:0], 1'b0} ^ (fb ? CrcPoly : 16'h0000);
    end
    return r;
  endfunction

  function automatic frame_word_t make_word(input kind_e k, input logic [7:0] cmd,
                                            input logic [5:0] len, input logic [4:0] idx,
                                            input logic [7:0] data, input logic last);
    frame_word_t w;
    w.kind     = k;
    w.command  = cmd;
    w.length   = len;
    w.index    = idx;
    w.data     = data;
    w.last     = last;
    w.crc_errs = crc_errs;
    return w;
  endfunction

  function automatic string word_text(input frame_word_t w);
    return $sformatf("kind %0d cmd %02h len %0d idx %0d data %02h last %0d errs %0d",
                     w.kind, w.command, w.length, w.index, w.data, w.last, w.crc_errs);
  endfunction

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  // advance the shadow parser by one accepted byte, queue what it emits
  task automatic parse_rx_byte(input logic [7:0] b);
    logic [15:0] got;
    case (scan)
      SCAN_LEN: begin
        if (b > MaxPayload) begin
          exp_words_q.push_back(make_word(KIND_LEN_ERR, 8'h00, (b > 63) ? 6'd63 : b[5:0],
                                          '0, 8'h00, 1'b1));
          scan = SCAN_HUNT;
        end else begin
          frame_len = b[5:0];
          rx_count  = 0;
          crc_acc   = crc_ccitt_next(CrcInit, b);
          scan      = SCAN_CMD;
        end
      end
      SCAN_CMD: begin
        frame_cmd = b;
        crc_acc   = crc_ccitt_next(crc_acc, b);
        scan      = (frame_len != 0) ? SCAN_PAYLOAD : SCAN_CRC_HI;
      end
      SCAN_PAYLOAD: begin
        payload_mem[rx_count] = b;
        rx_count++;
        crc_acc = crc_ccitt_next(crc_acc, b);
        if (rx_count >= frame_len) scan = SCAN_CRC_HI;
      end
      SCAN_CRC_HI: begin
        crc_hi = b;
        scan   = SCAN_CRC_LO;
      end
      SCAN_CRC_LO: begin
        got  = {crc_hi, b};
        scan = SCAN_HUNT;
        if (got != crc_acc) begin
          if (crc_errs != CntMax) crc_errs++;
          exp_words_q.push_back(make_word(KIND_CRC_ERR, frame_cmd, frame_len, '0, 8'h00, 1'b1));
        end else if (frame_len == 0) begin
          exp_words_q.push_back(make_word(KIND_GOOD, frame_cmd, 6'd0, '0, 8'h00, 1'b1));
        end else begin
          for (int i = 0; i < frame_len; i++) begin
            exp_words_q.push_back(make_word(KIND_GOOD, frame_cmd, frame_len, 5'(i),
                                            payload_mem[i], i + 1 == frame_len));
          end
        end
      end
      default: begin
        scan = (b == marker) ? SCAN_LEN : SCAN_HUNT;
      end
    endcase
  endtask

  // queue one frame; keep < 0 sends it whole, else only its first keep bytes
  task automatic add_frame(input int len, input logic [7:0] cmd, input bit bad_crc,
                           input int keep = -1, input int fill = -1);
    logic [7:0]  fr[$];
    logic [7:0]  b;
    logic [15:0] c;
    int          n;
    fr.push_back(marker);
    fr.push_back(8'(len));
    fr.push_back(cmd);
    c = crc_ccitt_next(CrcInit, 8'(len));
    c = crc_ccitt_next(c, cmd);
    for (int i = 0; i < len; i++) begin
      b = (fill < 0) ? 8'($urandom) : 8'(fill);
      fr.push_back(b);
      c = crc_ccitt_next(c, b);
    end
    if (bad_crc) c = c ^ (16'h0001 << $urandom_range(15, 0));
    fr.push_back(c[15:8]);
    fr.push_back(c[7:0]);
    n = (keep < 0 || keep > fr.size()) ? fr.size() : keep;
    for (int i = 0; i < n; i++) line_bytes_q.push_back(fr[i]);
  endtask

  task automatic random_traffic(input int budget);
    int base;
    int r;
    int len;
    int pick;
    base = line_bytes_q.size();
    while (line_bytes_q.size() - base < budget) begin
      r = $urandom_range(99, 0);
      if (r < 65) begin
        pick = $urandom_range(9, 0);
        len  = (pick < 6) ? $urandom_range(6, 0) :
               (pick < 9) ? $urandom_range(MaxPayload - 1, 7) : MaxPayload;
        add_frame(len, 8'($urandom), $urandom_range(4, 0) == 0);
      end else if (r < 75) begin
        line_bytes_q.push_back(marker);
        line_bytes_q.push_back(8'($urandom_range(255, MaxPayload + 1)));
      end else if (r < 88) begin
        repeat ($urandom_range(4, 1)) line_bytes_q.push_back(8'($urandom));
      end else begin
        // frame cut short, the following bytes land inside it
        len = $urandom_range(MaxPayload, 0);
        add_frame(len, 8'($urandom), 1'b0, $urandom_range(len + 4, 1));
      end
    end
  endtask

  // send everything, bring the parser back to hunting, wait for all words
  task automatic settle();
    do begin
      while (line_bytes_q.size() != 0 || rx_if.valid) @(negedge clk_i);
      if (scan != SCAN_HUNT) line_bytes_q.push_back(~marker);
    end while (scan != SCAN_HUNT);
    while (exp_words_q.size() != 0) @(negedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_marker(input logic [7:0] v);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    marker = v;
    @(negedge clk_i);
  endtask

  // sender
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rx_if.valid <= 1'b0;
    end else begin
      if (rx_if.valid && rx_if.ready) parse_rx_byte(rx_if.rx_byte);
      if (!rx_if.valid || rx_if.ready) begin
        if (line_bytes_q.size() != 0 && (gaps_off || $urandom_range(99, 0) >= 14)) begin
          rx_if.valid   <= 1'b1;
          rx_if.rx_byte <= line_bytes_q.pop_front();
        end else begin
          rx_if.valid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk_i) begin : result_check
    frame_word_t want;
    frame_word_t got;
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        words_seen++;
        got.kind     = res_if.kind;
        got.command  = res_if.command;
        got.length   = res_if.length;
        got.index    = res_if.index;
        got.data     = res_if.data;
        got.last     = res_if.last;
        got.crc_errs = res_if.crc_error_count;
        if (exp_words_q.size() == 0) begin
          note_failure({"unexpected word: ", word_text(got)});
        end else begin
          want = exp_words_q.pop_front();
          if (got.kind !== want.kind || got.command !== want.command ||
              got.length !== want.length || got.index !== want.index ||
              got.data !== want.data || got.last !== want.last ||
              got.crc_errs !== want.crc_errs) begin
            note_failure({"word mismatch\n  expected: ", word_text(want),
                          "\n  actual:   ", word_text(got)});
          end
        end
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        res_if.ready <= 1'b0;
      end else if (!holdoff_done && words_seen >= 12) begin
        // long stall so the outcome queue and payload banks fill up
        holdoff_done = 1'b1;
        holdoff_left = HoldoffCycles;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= gaps_off || ($urandom_range(99, 0) >= 14);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("watchdog: no word moved for %0d cycles", idle_cycles);
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_ni        = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = 8'h00;
    rx_if.valid   = 1'b0;
    rx_if.rx_byte = 8'h00;
    res_if.ready  = 1'b0;
    gaps_off      = 1'b0;
    fail_count    = 0;
    words_seen    = 0;
    holdoff_left  = 0;
    holdoff_done  = 1'b0;
    idle_cycles   = 0;
    scan          = SCAN_HUNT;
    marker        = MarkerReset;
    frame_len     = '0;
    frame_cmd     = '0;
    rx_count      = 0;
    crc_acc       = CrcInit;
    crc_hi        = '0;
    crc_errs      = '0;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: noise, empty frame, marker as payload, both length errors, bad CRC
    line_bytes_q.push_back(8'h00);
    line_bytes_q.push_back(8'hFF);
    add_frame(0, 8'h00, 1'b0);
    add_frame(1, 8'hFF, 1'b0, -1, MarkerReset);
    line_bytes_q.push_back(marker);
    line_bytes_q.push_back(8'(MaxPayload + 1));
    line_bytes_q.push_back(marker);
    line_bytes_q.push_back(8'hFF);
    add_frame(1, 8'h5A, 1'b1, -1, 8'h00);
    random_traffic(70);
    settle();

    write_marker(8'h00);
    random_traffic(70);
    settle();

    write_marker(8'hFF);
    gaps_off = 1'b1;
    random_traffic(70);
    settle();
    gaps_off = 1'b0;

    write_marker(8'($urandom));
    random_traffic(40);
    settle();

    write_marker(MarkerReset);
    random_traffic(20);
    settle();

    repeat (20) @(posedge clk_i);
    if (exp_words_q.size() != 0)
      note_failure($sformatf("%0d words never arrived", exp_words_q.size()));
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
